// File: rtl/core/rbsl_pkg.sv
// ----------------------------------------------------------------------------
// rbsl_pkg
// Shared constants and codes for the ranked bitmap slot lookup core.
// ----------------------------------------------------------------------------
package rbsl_pkg;

  localparam int INDEX_BITS   = 16;
  localparam int BITMAP_WORDS = 64;
  localparam int WORD_BITS    = 32;
  localparam int WORD_SHIFT   = 5;
  localparam int WORD_ADDR_W  = $clog2(BITMAP_WORDS);
  localparam int WORD_HI_W    = INDEX_BITS - WORD_SHIFT;
  localparam int COUNT_W      = 12;
  localparam int RAM_W        = WORD_BITS + COUNT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    REQ_BEGIN = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_QUERY = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2
  } status_e;

endpackage

// File: rtl/core/rbsl_ram.sv
// ----------------------------------------------------------------------------
// rbsl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/ranked_bitmap_slot_lookup_core.sv
// ----------------------------------------------------------------------------
// ranked_bitmap_slot_lookup_core
// Presence bitmap of an ascending index set with per-word rank; maps an
// index to its dense slot.
// ----------------------------------------------------------------------------
// One beat is accepted every cycle unless the output stalls, and each beat
// gives exactly one result through the middle stage and the output register.
// In the accept cycle a begin or add updates the set registers and an add
// writes or a query reads the word RAM; the registered RAM word is then
// masked and counted to form the slot. Begin clears the per-word valid flags
// at once, so no clearing pass is needed after reset or begin. An output
// register and a single middle stage decouple the two sides.
module ranked_bitmap_slot_lookup_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] index_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  input  logic        s_axis_tlast,   // batch_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [11:0] slot, [15:12] zero
  output logic [2:0]  m_axis_tuser,   // [0] found, [2:1] status
  output logic        m_axis_tlast    // batch_end_out
);

  localparam int IW = rbsl_pkg::INDEX_BITS;
  localparam int CW = rbsl_pkg::COUNT_W;
  localparam int AW = rbsl_pkg::WORD_ADDR_W;
  localparam int WB = rbsl_pkg::WORD_BITS;
  localparam int HW = rbsl_pkg::WORD_HI_W;
  localparam int BW = rbsl_pkg::WORD_SHIFT;

  typedef struct packed {
    logic                 chk;
    logic                 zero_hit;
    logic                 wvld;
    logic [BW-1:0]        bitpos;
    rbsl_pkg::status_e    status;
    logic                 last;
  } stage_t;

  // set state
  logic                             nonempty_q, nonempty_d;
  logic [IW-1:0]                    first_q, first_d;
  logic [IW-1:0]                    last_q, last_d;
  logic [CW-1:0]                    count_q, count_d;
  logic [AW-1:0]                    last_w_q, last_w_d;
  logic [WB-1:0]                    cur_bits_q, cur_bits_d;
  logic [CW-1:0]                    cur_rank_q, cur_rank_d;
  logic [rbsl_pkg::BITMAP_WORDS-1:0] word_vld_q, word_vld_d;

  // pipeline
  logic   s1_vld_q, s1_vld_d;
  stage_t s1_q, s1_d;
  logic   out_vld_q, out_vld_d;
  logic [CW-1:0]     out_slot_q, out_slot_d;
  logic              out_found_q, out_found_d;
  rbsl_pkg::status_e out_status_q, out_status_d;
  logic              out_last_q, out_last_d;

  logic accept, advance;
  logic [IW-1:0] v, base, add_at, q_at;
  logic [HW-1:0] add_w, q_w;
  logic order_err, full_err, q_ok, same_word;
  logic [WB-1:0] new_bits;
  logic [CW-1:0] new_rank;
  logic ram_we, ram_re;
  logic [rbsl_pkg::RAM_W-1:0] ram_rdata;

  logic [WB-1:0] word_bits, below_mask;
  logic [CW-1:0] word_rank;
  logic          hit;
  logic [BW:0]   ones;

  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !s1_vld_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign v = s_axis_tdata[IW-1:0];

  // add checks
  assign base      = nonempty_q ? first_q : v;
  assign add_at    = v - base;
  assign add_w     = add_at[IW-1:BW];
  assign order_err = (v == '0) || (nonempty_q && (v <= last_q));
  assign full_err  = (add_w >= HW'(rbsl_pkg::BITMAP_WORDS)) || (count_q == rbsl_pkg::COUNT_MAX);
  assign same_word = nonempty_q && (add_w[AW-1:0] == last_w_q);
  assign new_bits  = (same_word ? cur_bits_q : '0) | (WB'(1) << add_at[BW-1:0]);
  assign new_rank  = same_word ? cur_rank_q : count_q;

  // query span check
  assign q_at = v - first_q;
  assign q_w  = q_at[IW-1:BW];
  assign q_ok = (v != '0) && nonempty_q && (v >= first_q) && (v <= last_q)
                && (q_w < HW'(rbsl_pkg::BITMAP_WORDS));

  always_comb begin
    nonempty_d = nonempty_q;
    first_d    = first_q;
    last_d     = last_q;
    count_d    = count_q;
    last_w_d   = last_w_q;
    cur_bits_d = cur_bits_q;
    cur_rank_d = cur_rank_q;
    word_vld_d = word_vld_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    s1_d.chk      = 1'b0;
    s1_d.zero_hit = 1'b0;
    s1_d.wvld     = word_vld_q[q_w[AW-1:0]];
    s1_d.bitpos   = q_at[BW-1:0];
    s1_d.status   = rbsl_pkg::ST_OK;
    s1_d.last     = s_axis_tlast;
    if (accept) begin
      unique case (rbsl_pkg::req_e'(s_axis_tuser))
        rbsl_pkg::REQ_BEGIN: begin
          nonempty_d = 1'b0;
          first_d    = IW'(1);
          last_d     = '0;
          count_d    = '0;
          word_vld_d = '0;
        end
        rbsl_pkg::REQ_ADD: begin
          if (order_err) begin
            s1_d.status = rbsl_pkg::ST_ORDER;
          end else if (full_err) begin
            s1_d.status = rbsl_pkg::ST_FULL;
          end else begin
            ram_we     = 1'b1;
            nonempty_d = 1'b1;
            if (!nonempty_q) begin
              first_d = v;
            end
            last_d     = v;
            count_d    = count_q + CW'(1);
            last_w_d   = add_w[AW-1:0];
            cur_bits_d = new_bits;
            cur_rank_d = new_rank;
            word_vld_d[add_w[AW-1:0]] = 1'b1;
          end
        end
        rbsl_pkg::REQ_QUERY: begin
          ram_re        = 1'b1;
          s1_d.chk      = q_ok;
          s1_d.zero_hit = (v == '0);
        end
        default: begin
        end
      endcase
    end
  end

  rbsl_ram #(
    .WIDTH (rbsl_pkg::RAM_W),
    .DEPTH (rbsl_pkg::BITMAP_WORDS)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (add_w[AW-1:0]),
    .wdata_i ({new_rank, new_bits}),
    .re_i    (ram_re),
    .raddr_i (q_w[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // rank within the word plus the word's base rank
  assign word_bits  = s1_q.wvld ? ram_rdata[WB-1:0] : '0;
  assign word_rank  = s1_q.wvld ? ram_rdata[rbsl_pkg::RAM_W-1:WB] : '0;
  assign hit        = s1_q.chk && word_bits[s1_q.bitpos];
  assign below_mask = (WB'(1) << s1_q.bitpos) - WB'(1);
  assign ones       = (BW+1)'($countones(word_bits & below_mask));

  always_comb begin
    s1_vld_d     = s1_vld_q;
    out_vld_d    = out_vld_q;
    out_slot_d   = out_slot_q;
    out_found_d  = out_found_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    if (advance) begin
      out_vld_d    = s1_vld_q;
      out_slot_d   = hit ? (word_rank + CW'(ones) + CW'(1)) : '0;
      out_found_d  = hit || s1_q.zero_hit;
      out_status_d = s1_q.status;
      out_last_d   = s1_q.last;
      s1_vld_d     = 1'b0;
    end
    if (accept) begin
      s1_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q   <= 1'b0;
      first_q      <= IW'(1);
      last_q       <= '0;
      count_q      <= '0;
      last_w_q     <= '0;
      cur_bits_q   <= '0;
      cur_rank_q   <= '0;
      word_vld_q   <= '0;
      s1_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      nonempty_q   <= nonempty_d;
      first_q      <= first_d;
      last_q       <= last_d;
      count_q      <= count_d;
      last_w_q     <= last_w_d;
      cur_bits_q   <= cur_bits_d;
      cur_rank_q   <= cur_rank_d;
      word_vld_q   <= word_vld_d;
      s1_vld_q     <= s1_vld_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    out_slot_q   <= out_slot_d;
    out_found_q  <= out_found_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(16 - CW)'(0), out_slot_q};
  assign m_axis_tuser  = {out_status_q, out_found_q};
  assign m_axis_tlast  = out_last_q;

endmodule
